// File: hdl/hitt_pkg.sv
// Shared types, codes and helpers for the heap-indexed tree table.
package hitt_pkg;

    localparam int KEY_W   = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;
    localparam int LEVEL_W = 3;
    localparam int IDX_W   = 16;
    localparam int WIDE_W  = 64;

    localparam logic [IDX_W-1:0] ROOT_KEY = 16'd1;

    typedef enum logic [1:0] {
        OP_SET_ROOT  = 2'd0,
        OP_ADD_LEFT  = 2'd1,
        OP_ADD_RIGHT = 2'd2,
        OP_LOOKUP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_EXISTS = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode             opcode;
        logic [KEY_W-1:0]    node_key;
        logic [DATA_W-1:0]   node_value;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  node_count;
        logic [LEVEL_W-1:0]  deepest_level;
        logic                tree_empty;
    } t_result;

    // floor(log2(key)) for a nonzero key, 0 for key zero
    function automatic logic [3:0] level_of(input logic [KEY_W-1:0] key);
        logic [3:0] lvl;
        lvl = 4'd0;
        for (int i = 0; i < KEY_W; i++) begin
            if (key[i]) begin
                lvl = 4'(i);
            end
        end
        return lvl;
    endfunction

endpackage

// File: hdl/hitt_stream_if.sv
// Valid/ready channel interfaces for input items and result items.
interface hitt_item_if;
    logic            valid;
    logic            ready;
    hitt_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hitt_result_if;
    logic              valid;
    logic              ready;
    hitt_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/heap_indexed_tree_table.sv
// Top level of the heap-indexed binary tree table.
//
//  channel    dir  handshake          payload
//  i_item     in   valid / ready      opcode, node_key, node_value
//  o_result   out  valid / ready      status, found, read_value, node_count,
//                                     deepest_level, tree_empty
//
// For each item the accept edge reads both presence bits and the value from the
// entry memories into registers, and the decide cycle then decides and writes
// back. The next item is taken once the decide cycle retires, so a new item is
// not accepted while the previous one is still being decided.
// After reset the presence memory is swept clear, all 2^TREE_LEVELS entries
// (256 by default), with ready low.
// A result waits in the output register; while it is held the decide cycle
// stalls with its read data and nothing is written.
module heap_indexed_tree_table #(
    parameter int TREE_LEVELS = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hitt_item_if.sink          i_item,
    hitt_result_if.source      o_result
);

    localparam int AW  = TREE_LEVELS;
    localparam int CW  = TREE_LEVELS;
    localparam int LVW = $clog2(TREE_LEVELS);

    // memory side
    logic                   clearing;
    logic                   valid_a;
    logic                   valid_b;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_value;

    // item held through the decide cycle
    logic                          r_busy;
    hitt_pkg::t_opcode             r_op;
    logic [hitt_pkg::KEY_W-1:0]    r_key;
    logic [hitt_pkg::DATA_W-1:0]   r_node_value;

    // running tree summary
    logic [CW-1:0]  r_count;
    logic [LVW-1:0] r_level;
    logic [CW-1:0]  n_count;
    logic [LVW-1:0] n_level;

    // output register
    logic              r_out_valid;
    hitt_pkg::t_result r_res;

    logic in_acc;
    logic done;

    // accept only with the decide stage empty and the sweep finished
    assign i_item.ready = !r_busy && !clearing;
    assign in_acc       = i_item.valid && i_item.ready;
    assign done         = r_busy && (!r_out_valid || o_result.ready);

    // read addresses come straight from the incoming payload (the root key for set-root)
    logic [hitt_pkg::IDX_W-1:0] in_key16;
    logic [hitt_pkg::IDX_W-1:0] in_child16;

    always_comb begin
        in_key16   = 16'(i_item.data.node_key);
        in_child16 = 16'({i_item.data.node_key,
                          i_item.data.opcode == hitt_pkg::OP_ADD_RIGHT});
        if (i_item.data.opcode == hitt_pkg::OP_SET_ROOT) begin
            rd_addr_a = hitt_pkg::ROOT_KEY[AW-1:0];
        end else begin
            rd_addr_a = in_key16[AW-1:0];
        end
        rd_addr_b = in_child16[AW-1:0];
    end

    hitt_store #(
        .AW          (AW),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_value  (wr_value),
        .o_valid_a   (valid_a),
        .o_valid_b   (valid_b),
        .o_value     (rd_value),
        .o_clearing  (clearing)
    );

    // decide cycle
    logic [hitt_pkg::IDX_W-1:0]  key16;
    logic [hitt_pkg::IDX_W-1:0]  child16;
    logic                        key_rng;
    logic                        child_rng;
    logic [3:0]                  child_lvl;
    logic [hitt_pkg::WIDE_W-1:0] rd_wide;
    logic [hitt_pkg::WIDE_W-1:0] wr_wide;
    logic [hitt_pkg::WIDE_W-1:0] cnt_wide;
    logic [hitt_pkg::WIDE_W-1:0] lvl_wide;
    hitt_pkg::t_status           status;
    logic                        found;
    logic [hitt_pkg::DATA_W-1:0] read_value;
    logic                        wr_req;
    logic                        is_new;
    logic [LVW-1:0]              new_lvl;

    always_comb begin
        key16     = 16'(r_key);
        child16   = 16'({r_key, r_op == hitt_pkg::OP_ADD_RIGHT});
        key_rng   = (key16 >> AW) == '0;
        child_rng = (child16 >> AW) == '0;
        // a child sits one level below its parent
        child_lvl = hitt_pkg::level_of(r_key) + 4'd1;
        rd_wide   = 64'(rd_value);
        wr_wide   = 64'(r_node_value);

        status     = hitt_pkg::ST_OK;
        found      = 1'b0;
        read_value = '0;
        wr_req     = 1'b0;
        wr_addr    = child16[AW-1:0];
        is_new     = 1'b0;
        new_lvl    = '0;

        case (r_op)
            hitt_pkg::OP_SET_ROOT: begin
                // overwrite keeps the count, a fresh root adds one
                wr_req  = 1'b1;
                wr_addr = hitt_pkg::ROOT_KEY[AW-1:0];
                is_new  = !valid_a;
            end
            hitt_pkg::OP_LOOKUP: begin
                if (!key_rng) begin
                    status = hitt_pkg::ST_RANGE;
                end else if (valid_a) begin
                    found      = 1'b1;
                    read_value = rd_wide[hitt_pkg::DATA_W-1:0];
                end else begin
                    status = hitt_pkg::ST_ABSENT;
                end
            end
            hitt_pkg::OP_ADD_LEFT, hitt_pkg::OP_ADD_RIGHT: begin
                // parent check comes first, then child range, then occupancy
                if (!(key_rng && valid_a)) begin
                    status = hitt_pkg::ST_ABSENT;
                end else if (!child_rng) begin
                    status = hitt_pkg::ST_RANGE;
                end else if (valid_b) begin
                    status = hitt_pkg::ST_EXISTS;
                end else begin
                    wr_req  = 1'b1;
                    is_new  = 1'b1;
                    new_lvl = child_lvl[LVW-1:0];
                end
            end
            default: begin
                status = hitt_pkg::ST_OK;
            end
        endcase

        n_count = r_count + CW'(is_new);
        if (is_new && (new_lvl > r_level)) begin
            n_level = new_lvl;
        end else begin
            n_level = r_level;
        end
        cnt_wide = 64'(n_count);
        lvl_wide = 64'(n_level);
    end

    // write back only when the item retires
    assign wr_en    = done && wr_req;
    assign wr_value = wr_wide[VALUE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_level     <= '0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_level     <= n_level;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold the item, load the result on retire
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op         <= i_item.data.opcode;
            r_key        <= i_item.data.node_key;
            r_node_value <= i_item.data.node_value;
        end
        if (done) begin
            r_res.status        <= status;
            r_res.found         <= found;
            r_res.read_value    <= read_value;
            r_res.node_count    <= cnt_wide[hitt_pkg::COUNT_W-1:0];
            r_res.deepest_level <= lvl_wide[hitt_pkg::LEVEL_W-1:0];
            r_res.tree_empty    <= (n_count == '0);
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_res;

endmodule

// File: hdl/hitt_store.sv
// Entry memories: presence bits with a clearing pass, and entry values.
module hitt_store #(
    parameter int AW          = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr_a,
    input  logic [AW-1:0]          i_rd_addr_b,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [VALUE_WIDTH-1:0] i_wr_value,
    output logic                   o_valid_a,
    output logic                   o_valid_b,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_clearing
);

    localparam int DEPTH = 1 << AW;

    logic                   valid_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] value_mem [DEPTH];

    logic                   r_clearing;
    logic [AW-1:0]          r_clr_idx;
    logic                   r_valid_a;
    logic                   r_valid_b;
    logic [VALUE_WIDTH-1:0] r_value;

    // sweep every presence bit to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            valid_mem[r_clr_idx] <= 1'b0;
        end else if (i_wr_en) begin
            valid_mem[i_wr_addr] <= 1'b1;
        end
        if (i_wr_en) begin
            value_mem[i_wr_addr] <= i_wr_value;
        end
        if (i_rd_en) begin
            r_valid_a <= valid_mem[i_rd_addr_a];
            r_valid_b <= valid_mem[i_rd_addr_b];
            r_value   <= value_mem[i_rd_addr_a];
        end
    end

    assign o_valid_a  = r_valid_a;
    assign o_valid_b  = r_valid_b;
    assign o_value    = r_value;
    assign o_clearing = r_clearing;

endmodule
